// ===== src/tds_pkg.sv =====
`default_nettype none

package tds_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int IO_W       = 32;
  localparam int IO_FRAC    = 16;
  localparam int ROW_IDX_W  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd2;

  localparam logic [1:0] METHOD_THOMAS = 2'd0;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_CAP  = 2'd1;
  localparam logic [1:0] STATUS_ZDIV = 2'd2;

  localparam logic [30:0] TOL_RESET     = 31'd66;
  localparam logic [15:0] MAX_ITER_RESET = 16'd1000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_T_FETCH,
    S_B_FETCH,
    S_I_START,
    S_I_PRIME,
    S_I_FETCH,
    S_GO,
    S_WAIT,
    S_I_CHECK,
    S_OUT_FETCH,
    S_OUT_PUT
  } state_e;

  typedef enum logic [2:0] {
    ST_T_MUL_R,
    ST_T_DIV_R,
    ST_T_MUL_O,
    ST_T_DIV_O,
    ST_B_MUL,
    ST_I_MUL_W,
    ST_I_MUL_E,
    ST_I_DIV
  } step_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic zdiv;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/tds_alu.sv =====
`default_nettype none

module tds_alu #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tds_pkg::alu_req_t req_i,
  input  wire logic [W-1:0]      a_i,
  input  wire logic [W-1:0]      b_i,
  output tds_pkg::alu_rsp_t      rsp_o,
  output logic [W-1:0]           result_o
);

  localparam int QW   = W + F;
  localparam int MW   = (2 * W > QW) ? 2 * W : QW;
  localparam int CNTW = $clog2(QW + 1);

  logic              busy_q, done_q, zdiv_q, neg_q;
  logic [CNTW-1:0]   cnt_q;
  tds_pkg::alu_op_e  op_q;
  logic [W-1:0]      xm_q, rem_q, res_q;
  logic [2*W-1:0]    p_q;
  logic [QW-1:0]     quo_q;

  logic [W-1:0]  ma, mb;
  logic          div_zero;
  logic [W:0]    mul_sum, div_rs;
  logic          div_ge;
  logic [MW-1:0] fin_mag, fin_lim;
  logic [W-1:0]  fin_sat;

  always_comb begin
    ma       = a_i[W-1] ? W'(-a_i) : a_i;
    mb       = b_i[W-1] ? W'(-b_i) : b_i;
    div_zero = (req_i.op == tds_pkg::ALU_DIV) && (mb == '0);
    mul_sum  = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, xm_q} : '0);
    div_rs   = {rem_q, quo_q[QW-1]};
    div_ge   = div_rs >= {1'b0, xm_q};
    fin_mag  = (op_q == tds_pkg::ALU_MUL) ? MW'(p_q >> F) : MW'(quo_q);
    fin_lim  = (MW'(1) << (W - 1)) - MW'(!neg_q);
    fin_sat  = (fin_mag > fin_lim) ? fin_lim[W-1:0] : fin_mag[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (div_zero) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= (req_i.op == tds_pkg::ALU_MUL) ? CNTW'(W) : CNTW'(QW);
        end
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      neg_q  <= a_i[W-1] ^ b_i[W-1];
      zdiv_q <= div_zero;
      res_q  <= '0;
      rem_q  <= '0;
      if (req_i.op == tds_pkg::ALU_MUL) begin
        xm_q <= ma;
        p_q  <= {{W{1'b0}}, mb};
      end else begin
        xm_q  <= mb;
        quo_q <= {ma, {F{1'b0}}};
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (op_q == tds_pkg::ALU_MUL) begin
          p_q <= {mul_sum, p_q[W-1:1]};
        end else begin
          rem_q <= div_ge ? W'(div_rs - {1'b0, xm_q}) : div_rs[W-1:0];
          quo_q <= {quo_q[QW-2:0], div_ge};
        end
      end else begin
        res_q <= neg_q ? W'(-fin_sat) : fin_sat;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zdiv = zdiv_q;
  assign result_o   = res_q;

endmodule

`default_nettype wire

// ===== src/tridiagonal_system_solver.sv =====
`default_nettype none

// Solves a tridiagonal system in signed Q16.16, loaded one row per transfer (one row per
// cycle while in_ready_o is high): center*x[i] = west*x[i-1] + east*x[i+1] + source.
// The row flagged last_row starts a solve over the stored rows (at most MAX_ROWS); no row
// is taken until the last result of that solve has reached the output register. Each
// result is read from the solution store and then held in the output register until it
// is taken. All multiplies and divides run on one shared bit-serial unit, shift-and-add
// for a multiply and restoring for a divide. A Thomas solve runs a forward sweep and then
// a back substitution; each Jacobi or Gauss-Seidel sweep is repeated until the largest
// change is within the tolerance or max_iterations sweeps have run (status 1). A zero
// divisor gives a zero quotient and status 2. Values saturate on overflow; division
// truncates toward zero.

module tridiagonal_system_solver #(
  parameter int MAX_ROWS      = 64,
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tds_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [tds_pkg::IO_W-1:0]     west_coef_i,
  input  wire logic signed [tds_pkg::IO_W-1:0]     center_coef_i,
  input  wire logic signed [tds_pkg::IO_W-1:0]     east_coef_i,
  input  wire logic signed [tds_pkg::IO_W-1:0]     source_term_i,
  input  wire logic                                last_row_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [tds_pkg::IO_W-1:0]          solution_o,
  output logic [tds_pkg::ROW_IDX_W-1:0]            row_index_o,
  output logic [1:0]                               status_o,
  output logic                                     last_result_o
);

  localparam int W    = VALUE_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int IOW  = tds_pkg::IO_W;
  localparam int IW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam int UP   = (F >= tds_pkg::IO_FRAC) ? F - tds_pkg::IO_FRAC : 0;
  localparam int DN   = (F >= tds_pkg::IO_FRAC) ? 0 : tds_pkg::IO_FRAC - F;
  localparam int XW   = IOW + UP;
  localparam int LW   = (XW > W) ? XW : W;
  localparam int OW   = W + DN;
  localparam int LO   = (OW > IOW + 1) ? OW : IOW + 1;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_v(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic [W-1:0] fx_in(input logic [IOW-1:0] f);
    logic [IOW-1:0] m;
    logic [XW-1:0]  sc;
    logic [LW-1:0]  wide, lim;
    logic [W-1:0]   r;
    m    = f[IOW-1] ? IOW'(-f) : f;
    sc   = (XW'(m) << UP) >> DN;
    wide = LW'(sc);
    lim  = (LW'(1) << (W - 1)) - LW'(!f[IOW-1]);
    r    = (wide > lim) ? lim[W-1:0] : wide[W-1:0];
    return f[IOW-1] ? W'(-r) : r;
  endfunction

  function automatic logic [W-1:0] fx_tol(input logic [tds_pkg::CFG_DATA_W-1:0] t);
    logic [XW-1:0] sc;
    logic [LW-1:0] wide, lim;
    sc   = (XW'(t) << UP) >> DN;
    wide = LW'(sc);
    lim  = (LW'(1) << (W - 1)) - LW'(1);
    return (wide > lim) ? lim[W-1:0] : wide[W-1:0];
  endfunction

  function automatic logic [IOW-1:0] fx_out(input logic [W-1:0] v);
    logic [OW-1:0]  o;
    logic [LO-1:0]  wide, lim;
    logic [IOW-1:0] r;
    o    = (OW'(mag_v(v)) << DN) >> UP;
    wide = LO'(o);
    lim  = (LO'(1) << (IOW - 1)) - LO'(!v[W-1]);
    r    = (wide > lim) ? lim[IOW-1:0] : wide[IOW-1:0];
    return v[W-1] ? IOW'(-r) : r;
  endfunction

  tds_pkg::state_e state_q, state_d;
  tds_pkg::step_e  step_q, step_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   n_q, n_d, rows_q, rows_d;
  logic [1:0]      method_q;
  logic [tds_pkg::CFG_DATA_W-1:0] tol_q;
  logic [15:0]     maxit_q, iter_q, iter_d;
  logic            first_q, first_d, zdiv_q, zdiv_d, capped_q, capped_d;
  logic            out_valid_q, out_valid_d;

  logic [IOW-1:0]  sol_q;
  logic [tds_pkg::ROW_IDX_W-1:0] ridx_q;
  logic [1:0]      ostat_q;
  logic            olast_q;

  logic [W-1:0] den_q, den_d, ratio_q, ratio_d, off_q, off_d, num_q, num_d;
  logic [W-1:0] wt_q, wt_d, west_val_q, west_val_d, xcur_q, xcur_d, maxchg_q, maxchg_d;

  logic [4*W-1:0] row_mem [MAX_ROWS];
  logic [2*W-1:0] rp_mem  [MAX_ROWS];
  logic [W-1:0]   x_mem   [MAX_ROWS];
  logic [4*W-1:0] row_rd_q;
  logic [2*W-1:0] rp_rd_q;
  logic [W-1:0]   x_rd_q;

  logic           row_we, row_re, rp_we, rp_re, x_we, x_re, out_load;
  logic [IW-1:0]  x_raddr;
  logic [W-1:0]   x_wdata;

  tds_pkg::alu_req_t alu_req;
  tds_pkg::alu_rsp_t alu_rsp;
  logic [W-1:0]      alu_a, alu_b, alu_res;

  logic [W-1:0]  rd_w, rd_c, rd_e, rd_s, rp_ratio, rp_off, xrd_val, tol_w, chg, sum1;
  logic [IW-1:0] last_idx;
  logic          at_first, at_last, in_xfer, converged, cap_hit;
  logic [15:0]   iter_inc, cap;

  always_comb begin
    rd_w      = row_rd_q[4*W-1:3*W];
    rd_c      = row_rd_q[3*W-1:2*W];
    rd_e      = row_rd_q[2*W-1:W];
    rd_s      = row_rd_q[W-1:0];
    rp_ratio  = rp_rd_q[2*W-1:W];
    rp_off    = rp_rd_q[W-1:0];
    xrd_val   = first_q ? '0 : x_rd_q;
    last_idx  = IW'(n_q - 1'b1);
    at_first  = idx_q == '0;
    at_last   = idx_q == last_idx;
    in_xfer   = in_valid_i && (state_q == tds_pkg::S_LOAD);
    tol_w     = fx_tol(tol_q);
    iter_inc  = iter_q + 16'd1;
    cap       = (maxit_q == '0) ? 16'd1 : maxit_q;
    converged = maxchg_q <= tol_w;
    cap_hit   = iter_inc >= cap;
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      tds_pkg::S_LOAD: begin
        if (in_xfer && last_row_i) begin
          state_d = (method_q == tds_pkg::METHOD_THOMAS) ? tds_pkg::S_T_FETCH
                                                         : tds_pkg::S_I_START;
        end
      end
      tds_pkg::S_T_FETCH: begin
        state_d = tds_pkg::S_GO;
        step_d  = tds_pkg::ST_T_MUL_R;
      end
      tds_pkg::S_B_FETCH: begin
        state_d = tds_pkg::S_GO;
        step_d  = tds_pkg::ST_B_MUL;
      end
      tds_pkg::S_I_START: state_d = tds_pkg::S_I_PRIME;
      tds_pkg::S_I_PRIME: state_d = tds_pkg::S_I_FETCH;
      tds_pkg::S_I_FETCH: begin
        state_d = tds_pkg::S_GO;
        step_d  = tds_pkg::ST_I_MUL_W;
      end
      tds_pkg::S_GO: state_d = tds_pkg::S_WAIT;
      tds_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          case (step_q)
            tds_pkg::ST_T_MUL_R: begin
              state_d = tds_pkg::S_GO;
              step_d  = tds_pkg::ST_T_DIV_R;
            end
            tds_pkg::ST_T_DIV_R: begin
              state_d = tds_pkg::S_GO;
              step_d  = tds_pkg::ST_T_MUL_O;
            end
            tds_pkg::ST_T_MUL_O: begin
              state_d = tds_pkg::S_GO;
              step_d  = tds_pkg::ST_T_DIV_O;
            end
            tds_pkg::ST_T_DIV_O: begin
              if (!at_last) state_d = tds_pkg::S_T_FETCH;
              else if (at_first) state_d = tds_pkg::S_OUT_FETCH;
              else state_d = tds_pkg::S_B_FETCH;
            end
            tds_pkg::ST_B_MUL: begin
              state_d = at_first ? tds_pkg::S_OUT_FETCH : tds_pkg::S_B_FETCH;
            end
            tds_pkg::ST_I_MUL_W: begin
              state_d = tds_pkg::S_GO;
              step_d  = tds_pkg::ST_I_MUL_E;
            end
            tds_pkg::ST_I_MUL_E: begin
              state_d = tds_pkg::S_GO;
              step_d  = tds_pkg::ST_I_DIV;
            end
            tds_pkg::ST_I_DIV: begin
              state_d = at_last ? tds_pkg::S_I_CHECK : tds_pkg::S_I_FETCH;
            end
            default: state_d = tds_pkg::S_LOAD;
          endcase
        end
      end
      tds_pkg::S_I_CHECK: begin
        state_d = (converged || cap_hit) ? tds_pkg::S_OUT_FETCH : tds_pkg::S_I_START;
      end
      tds_pkg::S_OUT_FETCH: state_d = tds_pkg::S_OUT_PUT;
      tds_pkg::S_OUT_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = at_last ? tds_pkg::S_LOAD : tds_pkg::S_OUT_FETCH;
        end
      end
      default: state_d = tds_pkg::S_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o    = state_q == tds_pkg::S_LOAD;
    row_we        = in_xfer && (rows_q < CW'(MAX_ROWS));
    row_re        = (state_q == tds_pkg::S_T_FETCH) || (state_q == tds_pkg::S_I_FETCH);
    rp_re         = state_q == tds_pkg::S_B_FETCH;
    x_re          = 1'b0;
    x_raddr       = idx_q;
    out_load      = (state_q == tds_pkg::S_OUT_PUT) && (!out_valid_q || out_ready_i);
    alu_req.start = state_q == tds_pkg::S_GO;
    alu_req.op    = tds_pkg::ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (state_q)
      tds_pkg::S_I_START: begin
        x_re    = 1'b1;
        x_raddr = '0;
      end
      tds_pkg::S_I_FETCH: begin
        x_re    = 1'b1;
        x_raddr = idx_q + 1'b1;
      end
      tds_pkg::S_OUT_FETCH: x_re = 1'b1;
      default: x_re = 1'b0;
    endcase
    case (step_q)
      tds_pkg::ST_T_MUL_R: begin
        alu_a = at_first ? '0 : rd_w;
        alu_b = at_first ? '0 : ratio_q;
      end
      tds_pkg::ST_T_DIV_R: begin
        alu_req.op = tds_pkg::ALU_DIV;
        alu_a      = rd_e;
        alu_b      = den_q;
      end
      tds_pkg::ST_T_MUL_O: begin
        alu_a = at_first ? '0 : rd_w;
        alu_b = at_first ? '0 : off_q;
      end
      tds_pkg::ST_T_DIV_O: begin
        alu_req.op = tds_pkg::ALU_DIV;
        alu_a      = num_q;
        alu_b      = den_q;
      end
      tds_pkg::ST_B_MUL: begin
        alu_a = rp_ratio;
        alu_b = xcur_q;
      end
      tds_pkg::ST_I_MUL_W: begin
        alu_a = at_first ? '0 : rd_w;
        alu_b = at_first ? '0 : west_val_q;
      end
      tds_pkg::ST_I_MUL_E: begin
        alu_a = at_last ? '0 : rd_e;
        alu_b = at_last ? '0 : xrd_val;
      end
      tds_pkg::ST_I_DIV: begin
        alu_req.op = tds_pkg::ALU_DIV;
        alu_a      = num_q;
        alu_b      = rd_c;
      end
      default: alu_a = '0;
    endcase
  end

  // datapath
  always_comb begin
    idx_d      = idx_q;
    n_d        = n_q;
    rows_d     = rows_q;
    iter_d     = iter_q;
    first_d    = first_q;
    zdiv_d     = zdiv_q;
    capped_d   = capped_q;
    den_d      = den_q;
    ratio_d    = ratio_q;
    off_d      = off_q;
    num_d      = num_q;
    wt_d       = wt_q;
    west_val_d = west_val_q;
    xcur_d     = xcur_q;
    maxchg_d   = maxchg_q;
    rp_we      = 1'b0;
    x_we       = 1'b0;
    x_wdata    = alu_res;
    sum1       = sat_add(wt_q, alu_res);
    chg        = mag_v(sat_sub(xcur_q, alu_res));
    out_valid_d = (out_valid_q && !out_ready_i) || out_load;
    case (state_q)
      tds_pkg::S_LOAD: begin
        if (in_xfer) begin
          if (rows_q < CW'(MAX_ROWS)) rows_d = rows_q + 1'b1;
          if (last_row_i) begin
            n_d      = (rows_q < CW'(MAX_ROWS)) ? rows_q + 1'b1 : rows_q;
            rows_d   = '0;
            idx_d    = '0;
            zdiv_d   = 1'b0;
            capped_d = 1'b0;
            iter_d   = '0;
            first_d  = method_q != tds_pkg::METHOD_THOMAS;
          end
        end
      end
      tds_pkg::S_I_START: begin
        idx_d    = '0;
        maxchg_d = '0;
      end
      tds_pkg::S_I_PRIME: xcur_d = xrd_val;
      tds_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          zdiv_d = zdiv_q || alu_rsp.zdiv;
          case (step_q)
            tds_pkg::ST_T_MUL_R: den_d = sat_sub(rd_c, alu_res);
            tds_pkg::ST_T_DIV_R: ratio_d = alu_res;
            tds_pkg::ST_T_MUL_O: num_d = sat_add(rd_s, alu_res);
            tds_pkg::ST_T_DIV_O: begin
              off_d = alu_res;
              rp_we = 1'b1;
              if (at_last) begin
                x_we   = 1'b1;
                xcur_d = alu_res;
                if (!at_first) idx_d = idx_q - 1'b1;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            tds_pkg::ST_B_MUL: begin
              x_wdata = sat_add(alu_res, rp_off);
              x_we    = 1'b1;
              xcur_d  = x_wdata;
              if (!at_first) idx_d = idx_q - 1'b1;
            end
            tds_pkg::ST_I_MUL_W: wt_d = alu_res;
            tds_pkg::ST_I_MUL_E: num_d = sat_add(sum1, rd_s);
            tds_pkg::ST_I_DIV: begin
              x_we       = 1'b1;
              west_val_d = method_q[1] ? alu_res : xcur_q;
              xcur_d     = xrd_val;
              if (chg > maxchg_q) maxchg_d = chg;
              if (!at_last) idx_d = idx_q + 1'b1;
            end
            default: x_we = 1'b0;
          endcase
        end
      end
      tds_pkg::S_I_CHECK: begin
        iter_d  = iter_inc;
        first_d = 1'b0;
        if (converged || cap_hit) begin
          idx_d    = '0;
          capped_d = !converged;
        end
      end
      tds_pkg::S_OUT_PUT: begin
        if (out_load && !at_last) idx_d = idx_q + 1'b1;
      end
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tds_pkg::S_LOAD;
      step_q      <= tds_pkg::ST_T_MUL_R;
      idx_q       <= '0;
      n_q         <= '0;
      rows_q      <= '0;
      iter_q      <= '0;
      first_q     <= 1'b0;
      zdiv_q      <= 1'b0;
      capped_q    <= 1'b0;
      out_valid_q <= 1'b0;
      method_q    <= tds_pkg::METHOD_THOMAS;
      tol_q       <= tds_pkg::TOL_RESET;
      maxit_q     <= tds_pkg::MAX_ITER_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      rows_q      <= rows_d;
      iter_q      <= iter_d;
      first_q     <= first_d;
      zdiv_q      <= zdiv_d;
      capped_q    <= capped_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tds_pkg::CFG_METHOD:    method_q <= cfg_data_i[1:0];
          tds_pkg::CFG_TOLERANCE: tol_q    <= cfg_data_i;
          tds_pkg::CFG_MAX_ITER:  maxit_q  <= cfg_data_i[15:0];
          default:                method_q <= method_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q      <= den_d;
    ratio_q    <= ratio_d;
    off_q      <= off_d;
    num_q      <= num_d;
    wt_q       <= wt_d;
    west_val_q <= west_val_d;
    xcur_q     <= xcur_d;
    maxchg_q   <= maxchg_d;
    if (out_load) begin
      sol_q   <= fx_out(x_rd_q);
      ridx_q  <= tds_pkg::ROW_IDX_W'(idx_q);
      ostat_q <= zdiv_q ? tds_pkg::STATUS_ZDIV :
                 (capped_q ? tds_pkg::STATUS_CAP : tds_pkg::STATUS_OK);
      olast_q <= at_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[rows_q[IW-1:0]] <= {fx_in(west_coef_i), fx_in(center_coef_i),
                                  fx_in(east_coef_i), fx_in(source_term_i)};
    end
    if (row_re) row_rd_q <= row_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (rp_we) rp_mem[idx_q] <= {ratio_q, alu_res};
    if (rp_re) rp_rd_q <= rp_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[idx_q] <= x_wdata;
    if (x_re) x_rd_q <= x_mem[x_raddr];
  end

  tds_alu #(
    .W(W),
    .F(F)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  assign out_valid_o   = out_valid_q;
  assign solution_o    = sol_q;
  assign row_index_o   = ridx_q;
  assign status_o      = ostat_q;
  assign last_result_o = olast_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == tds_pkg::S_WAIT)
    else $error("arith unit finished outside wait state");

  a_solve_has_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tds_pkg::S_LOAD) |-> (n_q != '0) && (n_q <= CW'(MAX_ROWS)))
    else $error("solve running with bad row count");

  a_no_write_in_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tds_pkg::S_OUT_FETCH || state_q == tds_pkg::S_OUT_PUT) |-> !x_we && !rp_we)
    else $error("solution store written while results go out");

  a_start_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tds_pkg::S_LOAD && state_d != tds_pkg::S_LOAD) |=> rows_q == '0)
    else $error("row counter not cleared at solve start");

endmodule

`default_nettype wire
